/* design/gnsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnsm_pkg: shared types and constants of the gauge needle step mapper
// Angles are fixed point in 1/64 degree; a full turn is 23040 units.
// ----------------------------------------------------------------------------
package gnsm_pkg;

  // Gauge selector codes (input tuser, output tuser)
  localparam logic GAUGE_VVI = 1'b0;
  localparam logic GAUGE_AOA = 1'b1;

  // Configuration register indexes
  localparam logic CFG_VVI_ENABLE = 1'b0;
  localparam logic CFG_AOA_ENABLE = 1'b1;

  localparam int unsigned ANG_W = 15;

  localparam logic [14:0] TURN64      = 15'd23040;  // 360 deg
  localparam logic [14:0] HALF_TURN64 = 15'd11520;  // 180 deg
  localparam logic [14:0] QUARTER64   = 15'd5760;   // 360 - 270 deg
  localparam logic [15:0] MIRROR64    = 16'd34560;  // 180 + 360 deg
  localparam logic [14:0] AOA_SCALE   = 15'd17280;  // 270 deg
  localparam logic [15:0] FULLSCALE   = 16'hFFFF;

  // Vertical velocity: 12 * value is centered on 6 * full scale
  localparam logic [19:0] VVI_MID = 20'd393210;

  // Breakpoints of the velocity magnitude (multiples of full scale)
  localparam logic [18:0] VVI_X1 = 19'd65535;
  localparam logic [18:0] VVI_X2 = 19'd131070;
  localparam logic [18:0] VVI_X3 = 19'd262140;

  // Per-segment start, base angle and angle span of the interpolation
  localparam logic [18:0] SEG_X0   [4] = '{19'd0, 19'd65535, 19'd131070, 19'd262140};
  localparam logic [14:0] SEG_BASE [4] = '{15'd17280, 15'd21824, 15'd24256, 15'd26528};
  localparam logic [14:0] SEG_SPAN [4] = '{15'd4544, 15'd2432, 15'd2272, 15'd1549};

  // floor(z / 45) = (z * RECIP45) >> RECIP_SHIFT, exact for z below 2^22
  localparam logic [22:0] RECIP45     = 23'd5965233;
  localparam int unsigned RECIP_SHIFT = 28;

  typedef struct packed {
    logic        sel;
    logic [14:0] angle;
  } angle_item_t;

endpackage

/* design/gnsm_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnsm_angle: four-stage reading-to-angle pipeline
// Decode and segment select, multiply, divide by full scale, wrap and mirror.
// ----------------------------------------------------------------------------
module gnsm_angle (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_sel,
  input  logic [15:0]           in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gnsm_pkg::angle_item_t out_item
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1 registers
  logic        s1_sel_r, s1_neg_r, s1_half_r;
  logic [14:0] s1_base_r, s1_ma_r;
  logic [16:0] s1_mb_r;
  logic        s1_sel_nxt, s1_neg_nxt, s1_half_nxt;
  logic [14:0] s1_base_nxt, s1_ma_nxt;
  logic [16:0] s1_mb_nxt;
  // stage 2 registers
  logic        s2_sel_r, s2_neg_r, s2_half_r;
  logic [14:0] s2_base_r;
  logic [30:0] s2_prod_r, s2_prod_nxt;
  // stage 3 registers
  logic        s3_sel_r, s3_neg_r;
  logic [14:0] s3_base_r, s3_q_r, s3_q_nxt;
  // stage 4 registers
  logic        s4_sel_r;
  logic [14:0] s4_angle_r, s4_angle_nxt;

  // per-stage advance: a stage loads when it is empty or its successor loads
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: scale, fold magnitude, pick segment (velocity) or invert the reading (AOA)
  logic [19:0] t12;
  logic [18:0] mag;
  logic        neg;
  logic [1:0]  seg;
  logic [16:0] num_x;

  always_comb begin
    t12 = {1'b0, in_value, 3'b000} + {2'b00, in_value, 2'b00};
    if (t12 >= gnsm_pkg::VVI_MID) begin
      mag = 19'(t12 - gnsm_pkg::VVI_MID);
      neg = 1'b0;
    end else begin
      mag = 19'(gnsm_pkg::VVI_MID - t12);
      neg = 1'b1;
    end
    priority if (mag <= gnsm_pkg::VVI_X1) seg = 2'd0;
    else if (mag <= gnsm_pkg::VVI_X2)     seg = 2'd1;
    else if (mag <= gnsm_pkg::VVI_X3)     seg = 2'd2;
    else                                  seg = 2'd3;
    num_x = 17'(mag - gnsm_pkg::SEG_X0[seg]);

    s1_sel_nxt = in_sel;
    if (in_sel == gnsm_pkg::GAUGE_AOA) begin
      s1_ma_nxt   = gnsm_pkg::AOA_SCALE;
      s1_mb_nxt   = {1'b0, gnsm_pkg::FULLSCALE - in_value};
      s1_base_nxt = '0;
      s1_half_nxt = 1'b0;
      s1_neg_nxt  = 1'b0;
    end else begin
      s1_ma_nxt   = gnsm_pkg::SEG_SPAN[seg];
      s1_mb_nxt   = num_x;
      s1_base_nxt = gnsm_pkg::SEG_BASE[seg];
      s1_half_nxt = seg[1];
      s1_neg_nxt  = neg;
    end
  end

  // stage 2: span times offset
  logic [31:0] prod_full;
  assign prod_full   = {17'd0, s1_ma_r} * {15'd0, s1_mb_r};
  assign s2_prod_nxt = prod_full[30:0];

  // stage 3: rounded divide by 65535 (or 131070 on the wide segments)
  logic [31:0] xs;
  logic [30:0] xq;
  logic [16:0] hl;

  always_comb begin
    if (s2_half_r) begin
      xs = {1'b0, s2_prod_r} + 32'd65535;
      xq = xs[31:1];
    end else begin
      xs = {1'b0, s2_prod_r} + 32'd32767;
      xq = xs[30:0];
    end
    hl       = {2'b00, xq[30:16]} + {1'b0, xq[15:0]};
    s3_q_nxt = xq[30:16] + {14'd0, (hl >= 17'd65535)};
  end

  // stage 4: add base, wrap into a turn, mirror negative readings
  logic [15:0] u_sum, u_wrap, w_sum, w_wrap;

  always_comb begin
    u_sum  = {1'b0, s3_base_r} + {1'b0, s3_q_r};
    u_wrap = (u_sum >= {1'b0, gnsm_pkg::TURN64}) ? u_sum - {1'b0, gnsm_pkg::TURN64} : u_sum;
    w_sum  = gnsm_pkg::MIRROR64 - u_wrap;
    w_wrap = (w_sum >= {1'b0, gnsm_pkg::TURN64}) ? w_sum - {1'b0, gnsm_pkg::TURN64} : w_sum;
    s4_angle_nxt = s3_neg_r ? w_wrap[14:0] : u_wrap[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sel_r  <= s1_sel_nxt;
      s1_neg_r  <= s1_neg_nxt;
      s1_half_r <= s1_half_nxt;
      s1_base_r <= s1_base_nxt;
      s1_ma_r   <= s1_ma_nxt;
      s1_mb_r   <= s1_mb_nxt;
    end
    if (rdy2) begin
      s2_sel_r  <= s1_sel_r;
      s2_neg_r  <= s1_neg_r;
      s2_half_r <= s1_half_r;
      s2_base_r <= s1_base_r;
      s2_prod_r <= s2_prod_nxt;
    end
    if (rdy3) begin
      s3_sel_r  <= s2_sel_r;
      s3_neg_r  <= s2_neg_r;
      s3_base_r <= s2_base_r;
      s3_q_r    <= s3_q_nxt;
    end
    if (rdy4) begin
      s4_sel_r   <= s3_sel_r;
      s4_angle_r <= s4_angle_nxt;
    end
  end

  assign out_valid      = v4_r;
  assign out_item.sel   = s4_sel_r;
  assign out_item.angle = s4_angle_r;

`ifndef NO_ASSERTIONS
  a_angle_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (s4_angle_r < gnsm_pkg::TURN64))
    else $error("angle stage holds an angle outside one turn");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(s1_mb_r) && $stable(s1_ma_r)))
    else $error("stalled decode stage lost or changed its item");
`endif

endmodule

/* design/gnsm_steps.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnsm_steps: four-stage angle-to-step pipeline
// Relative angle, scale by steps per turn, divide by 23040, clamp and register.
// ----------------------------------------------------------------------------
module gnsm_steps #(
  parameter int unsigned STEPS_PER_REV = 945
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gnsm_pkg::angle_item_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_sel,
  output logic [9:0]            out_pos
);

  localparam logic [15:0] STEPS = 16'(STEPS_PER_REV);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic        s1_sel_r, s2_sel_r, s3_sel_r, s4_sel_r;
  logic [14:0] s1_rel_r, s1_rel_nxt;
  logic [30:0] s2_y_r, s2_y_nxt;
  logic [16:0] s3_q_r, s3_q_nxt;
  logic [9:0]  s4_pos_r, s4_pos_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: angle measured from 270 deg, turned the other way
  logic [15:0] r_sum;
  logic [14:0] r_wrap;

  always_comb begin
    r_sum  = {1'b0, in_item.angle} + {1'b0, gnsm_pkg::QUARTER64};
    r_wrap = (r_sum >= {1'b0, gnsm_pkg::TURN64}) ?
             15'(r_sum - {1'b0, gnsm_pkg::TURN64}) : r_sum[14:0];
    s1_rel_nxt = (r_wrap == '0) ? '0 : gnsm_pkg::TURN64 - r_wrap;
  end

  // stage 2: scale to steps, with half a turn unit of rounding
  logic [31:0] y_prod;
  assign y_prod   = {17'd0, s1_rel_r} * {16'd0, STEPS};
  assign s2_y_nxt = y_prod[30:0] + {16'd0, gnsm_pkg::HALF_TURN64};

  // stage 3: divide by 23040 = 512 * 45, the 45 through a reciprocal
  logic [44:0] q_prod;
  assign q_prod   = {23'd0, s2_y_r[30:9]} * {22'd0, gnsm_pkg::RECIP45};
  assign s3_q_nxt = q_prod[gnsm_pkg::RECIP_SHIFT +: 17];

  // stage 4: keep the top step out
  logic [15:0] top_step;
  assign top_step   = STEPS - 16'd1;
  assign s4_pos_nxt = (s3_q_r >= {1'b0, STEPS}) ? top_step[9:0] : s3_q_r[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sel_r <= in_item.sel;
      s1_rel_r <= s1_rel_nxt;
    end
    if (rdy2) begin
      s2_sel_r <= s1_sel_r;
      s2_y_r   <= s2_y_nxt;
    end
    if (rdy3) begin
      s3_sel_r <= s2_sel_r;
      s3_q_r   <= s3_q_nxt;
    end
    if (rdy4) begin
      s4_sel_r <= s3_sel_r;
      s4_pos_r <= s4_pos_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_sel   = s4_sel_r;
  assign out_pos   = s4_pos_r;

`ifndef NO_ASSERTIONS
  a_rel_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (s1_rel_r < gnsm_pkg::TURN64))
    else $error("relative angle outside one turn");

  a_pos_below_rev: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ({6'd0, s4_pos_r} < STEPS))
    else $error("step position reached a full revolution");
`endif

endmodule

/* design/gauge_needle_step_mapper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauge_needle_step_mapper_unit: gauge reading to stepper needle position
// Maps a 16-bit vertical-velocity or angle-of-attack reading to a needle
// target in whole steps; readings for a disabled gauge produce no transfer.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                     | tuser
//  --------+-----------+---------------------------+--------------------------
//  in_     | slave     | [15:0] gauge_value        | [0] req_type
//  out_    | master    | [9:0] step_position, zero | [0] motor_select
//  cfg_    | write     | wdata[0]: enable bit      | index 0 vvi, 1 aoa
//
// Rate: one reading per cycle while the result channel is not stalled; a result
// passes through eight register stages (four in the angle pipeline, four in
// the step pipeline, the last being the output register).
// Reset: synchronous rst_n clears both enables and all stage valid bits.
// Stalls: each stage holds its item while its successor is full and held, so bubbles
// close up and new readings are taken while a result waits at the output,
// until all eight stages hold an item.
// ----------------------------------------------------------------------------
module gauge_needle_step_mapper_unit #(
  parameter int unsigned STEPS_PER_REV = 945
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] gauge_value
  input  logic        in_tuser,   // [0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] step_position, [15:10] zero
  output logic        out_tuser,  // [0] motor_select
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  logic vvi_en_r, vvi_en_nxt;
  logic aoa_en_r, aoa_en_nxt;

  // Register writes: index selects the enable bit
  always_comb begin
    vvi_en_nxt = vvi_en_r;
    aoa_en_nxt = aoa_en_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        gnsm_pkg::CFG_VVI_ENABLE: vvi_en_nxt = cfg_wdata;
        gnsm_pkg::CFG_AOA_ENABLE: aoa_en_nxt = cfg_wdata;
        default:                  vvi_en_nxt = vvi_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvi_en_r <= 1'b0;
      aoa_en_r <= 1'b0;
    end else begin
      vvi_en_r <= vvi_en_nxt;
      aoa_en_r <= aoa_en_nxt;
    end
  end

  // A reading for a disabled gauge is still taken but enters as a bubble:
  // drop it here so that it never reaches the output.
  logic gauge_on;
  logic ang_in_valid;
  assign gauge_on     = (in_tuser == gnsm_pkg::GAUGE_AOA) ? aoa_en_r : vvi_en_r;
  assign ang_in_valid = in_tvalid && gauge_on;

  logic                  ang_valid, ang_ready;
  gnsm_pkg::angle_item_t ang_item;

  gnsm_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ang_in_valid),
    .in_ready  (in_tready),
    .in_sel    (in_tuser),
    .in_value  (in_tdata),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_item  (ang_item)
  );

  logic [9:0] pos;

  gnsm_steps #(
    .STEPS_PER_REV (STEPS_PER_REV)
  ) u_steps (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_item   (ang_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sel   (out_tuser),
    .out_pos   (pos)
  );

  assign out_tdata = {6'd0, pos};

endmodule

/* sim/tb_gauge_needle_step_mapper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gauge_needle_step_mapper_unit: self-checking bench of the needle mapper
// Drives gauge readings into the stream input and checks every needle
// position that comes out against its own predictor or a typed table value.
// A directed table comes first, then random readings under several enable
// settings and three idle profiles on the input and result channels.
// ----------------------------------------------------------------------------
module tb_gauge_needle_step_mapper_unit;

  localparam int unsigned STEPS    = 945;
  localparam int unsigned LATENCY  = 8;      // input transfer to result, per the block
  localparam int unsigned SETTLE   = LATENCY + 4;
  localparam int unsigned WATCHDOG = 5000;   // cycles without any transfer

  // Fixed point angle constants, 1/64 degree
  localparam longint unsigned FULL_TURN = 23040;
  localparam longint unsigned HALF_TURN = 11520;
  localparam longint unsigned ANG_270   = 17280;
  localparam longint unsigned SCALE_MAX = 65535;
  localparam longint unsigned VV_CENTER = 393210;  // 12 * value at zero velocity

  // Velocity magnitude breakpoints and table angles
  localparam longint unsigned VV_KNOT  [5] = '{0, 65535, 131070, 262140, 393210};
  localparam longint unsigned VV_ANGLE [5] = '{17280, 21824, 24256, 26528, 28077};

  typedef enum logic [1:0] {
    ROW_PREDICT,  // expectation comes from the predictor
    ROW_SILENT,   // gauge disabled: no result may appear
    ROW_TYPED     // expectation written into the table
  } row_kind_e;

  typedef struct packed {
    logic       en_vvi;
    logic       en_aoa;
    logic       gauge;
    logic [15:0] value;
    row_kind_e  kind;
    logic [9:0] step;
  } dir_row_t;

  typedef struct packed {
    logic       gauge;
    logic [9:0] step;
  } needle_t;

  // DUT connections; every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'd0;  // [15:0] gauge_value
  logic        in_tuser   = 1'b0;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [9:0] step_position, [15:10] zero
  logic        out_tuser;           // [0] motor_select
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_index  = gnsm_pkg::CFG_VVI_ENABLE;
  logic        cfg_wdata  = 1'b0;

  // Shadow of the enable registers, as the block holds them
  logic vvi_on = 1'b0;
  logic aoa_on = 1'b0;

  // Positions still owed by the block, oldest first
  needle_t pending_positions[$];
  needle_t head;

  int tx_idle = 14;
  int rx_idle = 54;
  int errors = 0;
  int idle_cycles = 0;
  int readings_sent = 0;
  int positions_checked = 0;
  int vvi_checked = 0;
  int aoa_checked = 0;
  int top_step_seen = 0;

  // Directed table: extremes of both gauges, the disabled gauge, the
  // top endpoint just above zero velocity, and both sides of the 2-unit
  // table point (the only breakpoint that whole readings can hit).
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, 1'b0, gnsm_pkg::GAUGE_VVI, 16'd0,     ROW_SILENT,  10'd0},
    '{1'b0, 1'b0, gnsm_pkg::GAUGE_AOA, 16'd65535, ROW_SILENT,  10'd0},
    '{1'b0, 1'b0, gnsm_pkg::GAUGE_VVI, 16'd65535, ROW_SILENT,  10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_AOA, 16'd0,     ROW_TYPED,   10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_AOA, 16'd65535, ROW_TYPED,   10'd709},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd32768, ROW_TYPED,   10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd32767, ROW_TYPED,   10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd32769, ROW_TYPED,   10'd944},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd32766, ROW_TYPED,   10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd65535, ROW_TYPED,   10'd502},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd0,     ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd43690, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd43689, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd43691, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd21845, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd21846, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd38229, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_AOA, 16'd1,     ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_AOA, 16'd32768, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b1, gnsm_pkg::GAUGE_AOA, 16'd65534, ROW_PREDICT, 10'd0},
    '{1'b1, 1'b0, gnsm_pkg::GAUGE_AOA, 16'd100,   ROW_SILENT,  10'd0},
    '{1'b1, 1'b0, gnsm_pkg::GAUGE_VVI, 16'd50000, ROW_PREDICT, 10'd0},
    '{1'b0, 1'b1, gnsm_pkg::GAUGE_VVI, 16'd50000, ROW_SILENT,  10'd0},
    '{1'b0, 1'b1, gnsm_pkg::GAUGE_AOA, 16'd12345, ROW_PREDICT, 10'd0}
  };

  // Random enable settings: both on, each alone, both off (few readings)
  localparam int N_SETTINGS = 4;
  localparam logic SET_VVI [N_SETTINGS] = '{1'b1, 1'b1, 1'b0, 1'b0};
  localparam logic SET_AOA [N_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0};
  localparam int   SET_LEN [N_SETTINGS] = '{300, 110, 110, 22};

  // Idle profiles: sender/receiver percent of idle cycles
  localparam int N_PROFILES = 3;
  localparam int TX_PCT [N_PROFILES] = '{14, 54, 0};
  localparam int RX_PCT [N_PROFILES] = '{54, 14, 0};

  gauge_needle_step_mapper_unit #(
    .STEPS_PER_REV(STEPS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Needle target in steps for one reading of the selected gauge
  function automatic logic [9:0] needle_step(input logic gauge, input logic [15:0] value);
    longint unsigned scaled, mag, span_x, span, num, angle, rel, steps;
    int seg;
    bit below_zero;
    if (gauge == gnsm_pkg::GAUGE_VVI) begin
      scaled = 12 * longint'(value);
      below_zero = (scaled < VV_CENTER);
      mag = below_zero ? VV_CENTER - scaled : scaled - VV_CENTER;
      // A magnitude on a knot belongs to the lower segment
      if (mag <= VV_KNOT[1]) seg = 0;
      else if (mag <= VV_KNOT[2]) seg = 1;
      else if (mag <= VV_KNOT[3]) seg = 2;
      else seg = 3;
      span_x = mag - VV_KNOT[seg];
      span = VV_KNOT[seg + 1] - VV_KNOT[seg];
      num = (VV_ANGLE[seg + 1] - VV_ANGLE[seg]) * span_x;
      angle = VV_ANGLE[seg] + (2 * num + span) / (2 * span);
      if (angle >= FULL_TURN) angle -= FULL_TURN;
      // Mirror descent readings about 180 degrees
      if (below_zero) angle = (HALF_TURN + FULL_TURN - angle) % FULL_TURN;
    end else begin
      angle = (2 * ANG_270 * (SCALE_MAX - value) + SCALE_MAX) / (2 * SCALE_MAX);
    end
    // Relative to 270 degrees, inverted, rounded to steps
    rel = (angle % FULL_TURN + FULL_TURN - ANG_270) % FULL_TURN;
    rel = (FULL_TURN - rel) % FULL_TURN;
    steps = (rel * STEPS * 2 + FULL_TURN) / (2 * FULL_TURN);
    // Top step is excluded: clamp a full revolution to the last step
    if (steps >= STEPS) steps = STEPS - 1;
    return steps[9:0];
  endfunction

  // Random reading, weighted toward the interesting regions of the scale
  function automatic logic [15:0] pick_reading();
    int off;
    off = int'($urandom_range(0, 32)) - 16;
    case ($urandom_range(0, 7))
      0, 1: return 16'(32768 + 2 * off);
      2:    return 16'(21845 + off);
      3:    return 16'(43690 + off);
      4:    return $urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                        : 16'(65535 - $urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one reading; on the transfer, record what the block owes for it
  task automatic send_reading(input logic gauge, input logic [15:0] value,
                              input row_kind_e kind, input logic [9:0] typed_step);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= gauge;
    do @(posedge clk); while (!in_tready);
    readings_sent++;
    case (kind)
      ROW_TYPED: pending_positions.push_back('{gauge, typed_step});
      ROW_PREDICT: begin
        if ((gauge == gnsm_pkg::GAUGE_VVI) ? vvi_on : aoa_on)
          pending_positions.push_back('{gauge, needle_step(gauge, value)});
      end
      default: ;
    endcase
  endtask

  // Hold the input off until every owed position has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
  endtask

  // Write both enables while the block is idle
  task automatic set_enables(input logic vvi, input logic aoa);
    wait_for_results();
    // Readings of a disabled gauge may still be in flight
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= gnsm_pkg::CFG_VVI_ENABLE;
    cfg_wdata <= vvi;
    @(negedge clk);
    cfg_index <= gnsm_pkg::CFG_AOA_ENABLE;
    cfg_wdata <= aoa;
    vvi_on = vvi;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    aoa_on = aoa;
  endtask

  // Receiver: stall at random according to the current profile
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // Check each result transfer against the oldest owed position; watch for hangs
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_positions.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual motor %0d step %0d",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        head = pending_positions.pop_front();
        if (out_tuser !== head.gauge) begin
          $display("%0t: motor_select mismatch: expected %0d, actual %0d",
                   $time, head.gauge, out_tuser);
          errors++;
        end
        if (out_tdata !== {6'd0, head.step}) begin
          $display("%0t: step_position mismatch: expected %0d, actual %0d",
                   $time, head.step, out_tdata);
          errors++;
        end
        positions_checked++;
        if (head.gauge == gnsm_pkg::GAUGE_VVI) vvi_checked++;
        else aoa_checked++;
        if (head.step == 10'(STEPS - 1)) top_step_seen++;
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog: no transfer for %0d cycles, %0d results owed",
               $time, idle_cycles, pending_positions.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, starting from the reset enables
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].en_vvi != vvi_on || DIR_TABLE[r].en_aoa != aoa_on)
        set_enables(DIR_TABLE[r].en_vvi, DIR_TABLE[r].en_aoa);
      send_reading(DIR_TABLE[r].gauge, DIR_TABLE[r].value,
                   DIR_TABLE[r].kind, DIR_TABLE[r].step);
    end

    // Random readings under every idle profile and enable setting
    for (int p = 0; p < N_PROFILES; p++) begin
      tx_idle = TX_PCT[p];
      rx_idle = RX_PCT[p];
      for (int s = 0; s < N_SETTINGS; s++) begin
        set_enables(SET_VVI[s], SET_AOA[s]);
        for (int i = 0; i < SET_LEN[s]; i++) begin
          // Once, drain completely in the middle of a busy stretch
          if (p == 0 && s == 0 && i == SET_LEN[s] / 2) wait_for_results();
          send_reading(logic'($urandom_range(0, 1)), pick_reading(), ROW_PREDICT, 10'd0);
        end
      end
    end

    // Drain, then give stray results time to show up
    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d readings; checked %0d positions (%0d vvi, %0d aoa, %0d at top step)",
             readings_sent, positions_checked, vvi_checked, aoa_checked, top_step_seen);
    $display("Covered all four enable settings under three idle profiles, %0d errors",
             errors);
    if (errors == 0 && pending_positions.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/gnsm_pkg.sv
design/gnsm_angle.sv
design/gnsm_steps.sv
design/gauge_needle_step_mapper_unit.sv
sim/tb_gauge_needle_step_mapper_unit.sv
